// ----- rtl/haptic_proxy_force_renderer_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the haptic proxy force renderer
// Shared wrappers around concurrent assertions clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef HAPTIC_PROXY_FORCE_RENDERER_TOP_MACROS_SVH
`define HAPTIC_PROXY_FORCE_RENDERER_TOP_MACROS_SVH

// Same-cycle implication.
`define HPFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define HPFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/hpfr_pkg.sv -----
// ----------------------------------------------------------------------------
// hpfr_pkg
// Types, scene constants and register indexes of the proxy force renderer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpfr_pkg;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 17;

    // Scene geometry in 1/256 mm.
    localparam logic signed [18:0] BALL_X = -19'sd14080;
    localparam logic signed [18:0] BALL_Y = 19'sd12800;
    localparam logic signed [18:0] BALL_Z = -19'sd6400;
    localparam logic signed [18:0] BOX_X  = 19'sd20480;
    localparam logic signed [18:0] BOX_Y  = 19'sd15360;
    localparam logic signed [18:0] BOX_Z  = 19'sd2560;
    localparam logic signed [17:0] BTN_X_LO = -18'sd15360;
    localparam logic signed [17:0] BTN_X_HI = 18'sd15360;
    localparam logic signed [17:0] BTN_Z_LO = -18'sd2560;
    localparam logic signed [17:0] BTN_Z_HI = 18'sd15360;

    typedef enum logic [2:0] {
        CFG_STIFFNESS = 3'd0,
        CFG_LEFT_WALL = 3'd1,
        CFG_RIGHT_WALL = 3'd2,
        CFG_FLOOR = 3'd3,
        CFG_RADIUS = 3'd4,
        CFG_HALF_SIDE = 3'd5,
        CFG_BUTTON = 3'd6,
        CFG_GRAVITY = 3'd7
    } hpfr_cfg_idx_t;

    typedef struct packed {
        logic [7:0]         stiffness;
        logic signed [17:0] left_wall;
        logic signed [17:0] right_wall;
        logic signed [17:0] floor_y;
        logic [15:0]        radius;
        logic [15:0]        half_side;
        logic signed [17:0] button_y;
        logic [9:0]         gravity;
    } hpfr_cfg_t;

    // One classified word handed from the front to the back.
    typedef struct packed {
        logic signed [17:0] px;
        logic signed [17:0] py;
        logic signed [17:0] pz;
        logic signed [17:0] qx;
        logic signed [17:0] qy;
        logic signed [17:0] qz;
        logic signed [18:0] dx;
        logic signed [18:0] dy;
        logic signed [18:0] dz;
        logic [31:0]        d2;
        logic               sph;
        logic               zero;
        logic               cube;
        logic [1:0]         cube_axis;
        logic signed [18:0] cube_val;
        logic               btn;
    } hpfr_item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQRT,
        BK_MUL,
        BK_PREP,
        BK_DIV,
        BK_DONE
    } hpfr_bstate_t;

endpackage

// ----- rtl/haptic_proxy_force_renderer_top.sv -----
// Throughput: one word per cycle for words outside the sphere, while the receiver does not stall the output.
// A sphere hit holds the back end through the bit-serial square root, a multiply
// and a setup step, the three parallel dividers and the output load.
// Reset clears all control state and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// haptic_proxy_force_renderer_top
// Proxy placement in a fixed scene with spring coupling force output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module haptic_proxy_force_renderer_top #(
    parameter int FIFO_DEPTH = hpfr_pkg::FIFO_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // pos_x, pos_y, pos_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // force_x, force_y, force_z, proxy_x, proxy_y, proxy_z
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [17:0]  cfg_data
);
    import hpfr_pkg::*;

    hpfr_cfg_t  cfg_reg;
    hpfr_item_t push_item, rd_item;
    logic       push, pop, full, empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stiffness  <= 8'd128;
            cfg_reg.left_wall  <= -18'sd30720;
            cfg_reg.right_wall <= 18'sd30720;
            cfg_reg.floor_y    <= -18'sd16640;
            cfg_reg.radius     <= 16'd8960;
            cfg_reg.half_side  <= 16'd5120;
            cfg_reg.button_y   <= -18'sd17408;
            cfg_reg.gravity    <= 10'd154;
        end
        else if (cfg_we)
        begin
            case (hpfr_cfg_idx_t'(cfg_addr))
                CFG_STIFFNESS:  cfg_reg.stiffness  <= cfg_data[7:0];
                CFG_LEFT_WALL:  cfg_reg.left_wall  <= $signed(cfg_data);
                CFG_RIGHT_WALL: cfg_reg.right_wall <= $signed(cfg_data);
                CFG_FLOOR:      cfg_reg.floor_y    <= $signed(cfg_data);
                CFG_RADIUS:     cfg_reg.radius     <= cfg_data[15:0];
                CFG_HALF_SIDE:  cfg_reg.half_side  <= cfg_data[15:0];
                CFG_BUTTON:     cfg_reg.button_y   <= $signed(cfg_data);
                CFG_GRAVITY:    cfg_reg.gravity    <= cfg_data[9:0];
                default:        cfg_reg.gravity    <= cfg_reg.gravity;
            endcase
        end
    end

    hpfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    hpfr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_item),
        .pop   (pop),
        .rdata (rd_item),
        .full  (full),
        .empty (empty)
    );

    hpfr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .rd_item  (rd_item),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/hpfr_front.sv -----
// ----------------------------------------------------------------------------
// hpfr_front
// Accepts positions, applies walls and floor, classifies sphere, cube and
// button hits and computes the squared sphere distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpfr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  hpfr_pkg::hpfr_cfg_t cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [55:0]       s_tdata,
    output logic              push,
    output hpfr_pkg::hpfr_item_t push_item,
    input  logic              full
);
    import hpfr_pkg::*;

    logic en;
    logic v1_reg, v2_reg;
    logic signed [17:0] p1_reg [3];

    logic signed [17:0] p2_reg [3];
    logic signed [17:0] q2_reg [3];
    logic signed [18:0] d2ax_reg [3];
    logic [37:0]        sq_reg [3];
    logic [31:0]        r2_reg;
    logic               cube_reg, btn_reg;
    logic [1:0]         axis_reg;
    logic signed [18:0] cval_reg;

    logic signed [18:0] ctr [3];
    logic signed [18:0] ball [3];
    logic signed [18:0] pe [3];
    logic signed [18:0] lo [3];
    logic signed [18:0] hi [3];
    logic signed [18:0] dc [3];
    logic signed [37:0] sq [3];
    logic signed [19:0] face_gap [6];
    logic signed [18:0] hh;
    logic               in_cube;
    logic [2:0]         near;
    logic signed [17:0] qx, qy;
    logic               btn;
    logic [39:0]        d2;

    assign en       = !v2_reg || !full;
    assign s_tready = en;
    assign push     = v2_reg && !full;

    assign ctr[0] = BOX_X;
    assign ctr[1] = BOX_Y;
    assign ctr[2] = BOX_Z;
    assign ball[0] = BALL_X;
    assign ball[1] = BALL_Y;
    assign ball[2] = BALL_Z;
    assign hh = $signed({3'b000, cfg.half_side});

    always_comb
    begin
        in_cube = (cfg.half_side != 16'd0);
        for (int i = 0; i < 3; i++)
        begin
            pe[i] = 19'(p1_reg[i]);
            dc[i] = pe[i] - ball[i];
            sq[i] = dc[i] * dc[i];
            lo[i] = ctr[i] - hh;
            hi[i] = ctr[i] + hh;
            if (!(lo[i] < pe[i] && pe[i] < hi[i]))
            begin
                in_cube = 1'b0;
            end
            face_gap[2 * i]     = 20'(pe[i]) - 20'(lo[i]);
            face_gap[2 * i + 1] = 20'(hi[i]) - 20'(pe[i]);
        end
        near = 3'd0;
        for (int i = 1; i < 6; i++)
        begin
            if (face_gap[i] < face_gap[near])
            begin
                near = 3'(i);
            end
        end
    end

    always_comb
    begin
        if (p1_reg[0] < cfg.left_wall)
        begin
            qx = cfg.left_wall;
        end
        else if (p1_reg[0] > cfg.right_wall)
        begin
            qx = cfg.right_wall;
        end
        else
        begin
            qx = p1_reg[0];
        end
        qy = (p1_reg[1] < cfg.floor_y) ? cfg.floor_y : p1_reg[1];
        btn = (p1_reg[0] > BTN_X_LO) && (p1_reg[0] < BTN_X_HI) &&
              (p1_reg[2] > BTN_Z_LO) && (p1_reg[2] < BTN_Z_HI) &&
              (p1_reg[1] < cfg.floor_y) && (p1_reg[1] <= cfg.button_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg[0] <= $signed(s_tdata[17:0]);
            p1_reg[1] <= $signed(s_tdata[35:18]);
            p1_reg[2] <= $signed(s_tdata[53:36]);
            for (int i = 0; i < 3; i++)
            begin
                p2_reg[i]   <= p1_reg[i];
                d2ax_reg[i] <= dc[i];
                sq_reg[i]   <= sq[i][37:0];
            end
            q2_reg[0] <= qx;
            q2_reg[1] <= qy;
            q2_reg[2] <= p1_reg[2];
            r2_reg    <= cfg.radius * cfg.radius;
            cube_reg  <= in_cube;
            axis_reg  <= near[2:1];
            cval_reg  <= near[0] ? hi[near[2:1]] : lo[near[2:1]];
            btn_reg   <= btn;
        end
    end

    assign d2 = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};

    always_comb
    begin
        push_item.px        = p2_reg[0];
        push_item.py        = p2_reg[1];
        push_item.pz        = p2_reg[2];
        push_item.qx        = q2_reg[0];
        push_item.qy        = q2_reg[1];
        push_item.qz        = q2_reg[2];
        push_item.dx        = d2ax_reg[0];
        push_item.dy        = d2ax_reg[1];
        push_item.dz        = d2ax_reg[2];
        push_item.d2        = d2[31:0];
        push_item.sph       = d2 < {8'd0, r2_reg};
        push_item.zero      = (d2 == 40'd0);
        push_item.cube      = cube_reg;
        push_item.cube_axis = axis_reg;
        push_item.cube_val  = cval_reg;
        push_item.btn       = btn_reg;
    end

endmodule

// ----- rtl/hpfr_fifo.sv -----
// ----------------------------------------------------------------------------
// hpfr_fifo
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpfr_fifo #(
    parameter int DEPTH = hpfr_pkg::FIFO_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hpfr_pkg::hpfr_item_t wdata,
    input  logic              pop,
    output hpfr_pkg::hpfr_item_t rdata,
    output logic              full,
    output logic              empty
);
    import hpfr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hpfr_item_t mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/hpfr_back.sv -----
// ----------------------------------------------------------------------------
// hpfr_back
// Places the proxy on the sphere surface with an iterative square root and
// three dividers, applies cube and button, and computes the spring force.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "haptic_proxy_force_renderer_top_macros.svh"

module hpfr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  hpfr_pkg::hpfr_cfg_t cfg,
    input  hpfr_pkg::hpfr_item_t rd_item,
    input  logic              empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [103:0]      m_tdata
);
    import hpfr_pkg::*;

    hpfr_bstate_t state_reg, state_next;
    hpfr_item_t   w_reg;
    logic [4:0]   cnt_reg;
    logic         out_free, out_load, needs;

    logic [47:0]  nsh_reg;
    logic [26:0]  rem_reg;
    logic [23:0]  root_reg;
    logic [26:0]  rem_sh, trial;
    logic         sq_ge;

    logic [31:0]  prod_reg [3];
    logic [23:0]  drem_reg [3];
    logic [16:0]  nb_reg [3];
    logic [16:0]  quot_reg [3];
    logic [40:0]  numer [3];
    logic [24:0]  dsh [3];
    logic         dge [3];

    logic signed [18:0] dax [3];
    logic signed [18:0] ball [3];
    logic signed [18:0] pre [3];
    logic signed [18:0] pp [3];
    logic signed [18:0] qf [3];
    logic signed [19:0] diff [3];
    logic signed [28:0] kd [3];
    logic signed [28:0] kr [3];
    logic signed [22:0] fs [3];
    logic signed [22:0] fg [3];
    logic [15:0]        fsat [3];
    logic [18:0]        mag [3];

    logic               m_tvalid_reg;
    logic [103:0]       m_tdata_reg;

    assign ball[0] = BALL_X;
    assign ball[1] = BALL_Y;
    assign ball[2] = BALL_Z;
    assign dax[0]  = w_reg.dx;
    assign dax[1]  = w_reg.dy;
    assign dax[2]  = w_reg.dz;
    assign pre[0]  = 19'(w_reg.qx);
    assign pre[1]  = 19'(w_reg.qy);
    assign pre[2]  = 19'(w_reg.qz);
    assign pp[0]   = 19'(w_reg.px);
    assign pp[1]   = 19'(w_reg.py);
    assign pp[2]   = 19'(w_reg.pz);

    assign out_free = !m_tvalid_reg || m_tready;
    assign needs    = rd_item.sph && !rd_item.zero;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    state_next = needs ? BK_SQRT : BK_DONE;
                end
            end
            BK_SQRT:
            begin
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:  state_next = BK_PREP;
            BK_PREP: state_next = BK_DIV;
            BK_DIV:
            begin
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    if (!empty)
                    begin
                        state_next = needs ? BK_SQRT : BK_DONE;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        pop      = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            BK_IDLE: pop = !empty;
            BK_DONE:
            begin
                out_load = out_free;
                pop      = out_free && !empty;
            end
            default:
            begin
                pop      = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // One root bit per cycle.
    assign rem_sh = {rem_reg[24:0], nsh_reg[47:46]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge  = (rem_sh >= trial);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i]   = dax[i][18] ? 19'(-dax[i]) : 19'(dax[i]);
            numer[i] = {1'b0, prod_reg[i], 8'd0} + {18'd0, root_reg[23:1]};
            dsh[i]   = {drem_reg[i], nb_reg[i][16]};
            dge[i]   = (dsh[i] >= {1'b0, root_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next == state_reg) ? cnt_reg + 1'b1 : '0;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            w_reg    <= rd_item;
            nsh_reg  <= {rd_item.d2, 16'd0};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (state_reg == BK_SQRT)
        begin
            nsh_reg  <= {nsh_reg[45:0], 2'b00};
            rem_reg  <= sq_ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[22:0], sq_ge};
        end
        for (int i = 0; i < 3; i++)
        begin
            case (state_reg)
                BK_MUL:
                begin
                    prod_reg[i] <= mag[i][15:0] * cfg.radius;
                end
                BK_PREP:
                begin
                    // The quotient never exceeds the radius, so the top bits
                    // of the numerator already sit below the divisor.
                    drem_reg[i] <= numer[i][40:17];
                    nb_reg[i]   <= numer[i][16:0];
                    quot_reg[i] <= '0;
                end
                BK_DIV:
                begin
                    drem_reg[i] <= dge[i] ? 24'(dsh[i] - {1'b0, root_reg}) : dsh[i][23:0];
                    nb_reg[i]   <= {nb_reg[i][15:0], 1'b0};
                    quot_reg[i] <= {quot_reg[i][15:0], dge[i]};
                end
                default:
                begin
                    prod_reg[i] <= prod_reg[i];
                end
            endcase
        end
        if (out_load)
        begin
            m_tdata_reg <= {2'b00, qf[2][17:0], qf[1][17:0], qf[0][17:0],
                            fsat[2], fsat[1], fsat[0]};
        end
    end

    // Final proxy and spring force.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (w_reg.sph && w_reg.zero)
            begin
                qf[i] = ball[i];
                if (i == 1)
                begin
                    qf[i] = ball[i] + $signed({3'b000, cfg.radius});
                end
            end
            else if (w_reg.sph)
            begin
                qf[i] = dax[i][18] ? ball[i] - $signed({2'b00, quot_reg[i]})
                                   : ball[i] + $signed({2'b00, quot_reg[i]});
            end
            else
            begin
                qf[i] = pre[i];
            end
            if (w_reg.cube && (w_reg.cube_axis == 2'(i)))
            begin
                qf[i] = w_reg.cube_val;
            end
            if (i == 1 && w_reg.btn)
            begin
                qf[i] = 19'(cfg.button_y);
            end
            diff[i] = 20'(qf[i]) - 20'(pp[i]);
            kd[i]   = $signed({1'b0, cfg.stiffness}) * diff[i];
            kr[i]   = kd[i] + 29'sd32;
            fs[i]   = 23'(kr[i] >>> 6);
            fg[i]   = (i == 1) ? fs[i] + $signed({13'd0, cfg.gravity}) : fs[i];
            if (fg[i] > 23'sd32767)
            begin
                fsat[i] = 16'h7fff;
            end
            else if (fg[i] < -23'sd32768)
            begin
                fsat[i] = 16'h8000;
            end
            else
            begin
                fsat[i] = fg[i][15:0];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `HPFR_ASSERT_NOW(a_pop_nonempty, pop, !empty)
    `HPFR_ASSERT_NEXT(a_sphere_root, pop && rd_item.sph && !rd_item.zero, state_reg == BK_SQRT)
    `HPFR_ASSERT_NOW(a_quot_bound, state_reg == BK_DONE && w_reg.sph && !w_reg.zero,
        quot_reg[0] <= {1'b0, cfg.radius} && quot_reg[1] <= {1'b0, cfg.radius})

endmodule

// ----- test/haptic_proxy_force_renderer_top_test.sv -----
// ----------------------------------------------------------------------------
// Proxy force renderer regression
// Drives device positions through the stream input and checks every output
// word against a scene predictor, across several register settings, with
// random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module haptic_proxy_force_renderer_top_test;
    import hpfr_pkg::*;

    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic signed [17:0] qx;
        logic signed [17:0] qy;
        logic signed [17:0] qz;
    } render_t;

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic               chk;
        render_t            want;
    } dir_row_t;

    localparam int LIMIT = 1500000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [55:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [17:0]  cfg_data;

    // Register copy used by the predictor.
    longint k_gain, wall_lo, wall_hi, floor_lvl, radius, half_side, btn_lvl, grav;

    render_t render_q[$];
    int      n_bad;
    int      n_out;
    bit      quiet;
    bit      hold_rx;
    bit      timed_out;
    int      cycle_cnt;

    haptic_proxy_force_renderer_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint root_floor(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sh4000_0000_0000_0000;
        while (b > n)
            b = b >>> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint ray_scale(longint dc, longint len);
        longint m;
        longint v;
        m = (dc < 0) ? -dc : dc;
        v = (m * radius * 256 + len / 2) / len;
        return (dc < 0) ? -v : v;
    endfunction

    function automatic longint pull(longint d);
        longint v;
        v = k_gain * d + 32;
        if (v >= 0)
            return v / 64;
        return -((-v + 63) / 64);
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic render_t render_proxy(logic signed [17:0] x, logic signed [17:0] y,
                                             logic signed [17:0] z);
        longint p[3], q[3], lo[3], hi[3], gap[6], ctr[3];
        longint dx, dy, dz, d2, len;
        int      i, best;
        bit      in_box;
        render_t r;
        p[0] = x; p[1] = y; p[2] = z;
        ctr[0] = BOX_X; ctr[1] = BOX_Y; ctr[2] = BOX_Z;
        for (i = 0; i < 3; i++)
            q[i] = p[i];
        if (p[0] < wall_lo)
            q[0] = wall_lo;
        else if (p[0] > wall_hi)
            q[0] = wall_hi;
        if (p[1] < floor_lvl)
            q[1] = floor_lvl;
        dx = p[0] - BALL_X;
        dy = p[1] - BALL_Y;
        dz = p[2] - BALL_Z;
        d2 = dx * dx + dy * dy + dz * dz;
        if (d2 < radius * radius)
        begin
            if (d2 == 0)
            begin
                q[0] = BALL_X; q[1] = BALL_Y + radius; q[2] = BALL_Z;
            end
            else
            begin
                len = root_floor(d2 <<< 16);
                q[0] = BALL_X + ray_scale(dx, len);
                q[1] = BALL_Y + ray_scale(dy, len);
                q[2] = BALL_Z + ray_scale(dz, len);
            end
        end
        in_box = 1'b1;
        for (i = 0; i < 3; i++)
        begin
            lo[i] = ctr[i] - half_side;
            hi[i] = ctr[i] + half_side;
            if (!(lo[i] < p[i] && p[i] < hi[i]))
                in_box = 1'b0;
        end
        if (in_box)
        begin
            for (i = 0; i < 3; i++)
            begin
                gap[2 * i] = p[i] - lo[i];
                gap[2 * i + 1] = hi[i] - p[i];
            end
            best = 0;
            for (i = 1; i < 6; i++)
                if (gap[i] < gap[best])
                    best = i;
            q[best / 2] = (best % 2) ? hi[best / 2] : lo[best / 2];
        end
        if (p[0] > BTN_X_LO && p[0] < BTN_X_HI && p[2] > BTN_Z_LO && p[2] < BTN_Z_HI &&
            p[1] < floor_lvl && p[1] <= btn_lvl)
            q[1] = btn_lvl;
        r.fx = clip16(pull(q[0] - p[0]));
        r.fy = clip16(pull(q[1] - p[1]) + grav);
        r.fz = clip16(pull(q[2] - p[2]));
        r.qx = q[0][17:0];
        r.qy = q[1][17:0];
        r.qz = q[2][17:0];
        return r;
    endfunction

    task automatic set_reg(hpfr_cfg_idx_t idx, logic [17:0] val);
        cfg_we   = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_STIFFNESS:  k_gain    = val[7:0];
            CFG_LEFT_WALL:  wall_lo   = $signed(val);
            CFG_RIGHT_WALL: wall_hi   = $signed(val);
            CFG_FLOOR:      floor_lvl = $signed(val);
            CFG_RADIUS:     radius    = val[15:0];
            CFG_HALF_SIDE:  half_side = val[15:0];
            CFG_BUTTON:     btn_lvl   = $signed(val);
            default:        grav      = val[9:0];
        endcase
    endtask

    task automatic drain();
        while (render_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Offers one word; the predicted result is queued when it is accepted.
    task automatic send_pos(logic signed [17:0] x, logic signed [17:0] y,
                            logic signed [17:0] z, bit pause);
        if (pause && !quiet && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 12)) @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        render_q.push_back(render_proxy(x, y, z));
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic signed [17:0] rnd18();
        return 18'($urandom());
    endfunction

    // Positions mostly clustered near the scene objects, some fully random, so every rule gets hit.
    task automatic send_random(bit pause);
        logic signed [17:0] x, y, z;
        int pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0:
            begin
                x = 18'(BALL_X + $signed($urandom_range(0, 2 * radius + 2)) - radius - 1);
                y = 18'(BALL_Y + $signed($urandom_range(0, 2 * radius + 2)) - radius - 1);
                z = 18'(BALL_Z + $signed($urandom_range(0, 2 * radius + 2)) - radius - 1);
            end
            1:
            begin
                x = 18'(BOX_X + $signed($urandom_range(0, 2 * half_side + 2)) - half_side - 1);
                y = 18'(BOX_Y + $signed($urandom_range(0, 2 * half_side + 2)) - half_side - 1);
                z = 18'(BOX_Z + $signed($urandom_range(0, 2 * half_side + 2)) - half_side - 1);
            end
            2:
            begin
                x = 18'($signed($urandom_range(0, 32000)) - 16000);
                y = 18'(btn_lvl + $signed($urandom_range(0, 2000)) - 1000);
                z = 18'($signed($urandom_range(0, 19000)) - 3000);
            end
            3:
            begin
                x = 18'($signed($urandom_range(0, 80000)) - 40000);
                y = 18'(floor_lvl + $signed($urandom_range(0, 4000)) - 2000);
                z = 18'($signed($urandom_range(0, 80000)) - 40000);
            end
            default:
            begin
                x = rnd18(); y = rnd18(); z = rnd18();
            end
        endcase
        send_pos(x, y, z, pause);
    endtask

    task automatic random_block(int n);
        for (int i = 0; i < n; i++)
            send_random(1'b1);
    endtask

    // Receiver with random stalls and an on-demand long hold-off.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rx)
                m_tready <= 1'b0;
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        render_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                   m_tdata[65:48], m_tdata[83:66], m_tdata[101:84]};
            n_out++;
            if (render_q.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected word %h", got);
            end
            else
            begin
                want = render_q.pop_front();
                if (got !== want)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: want f=%0d,%0d,%0d q=%0d,%0d,%0d ",
                                 want.fx, want.fy, want.fz, want.qx, want.qy, want.qz,
                                 "got f=%0d,%0d,%0d q=%0d,%0d,%0d",
                                 got.fx, got.fy, got.fz, got.qx, got.qy, got.qz);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT)
        begin
            timed_out = 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        int      hold;
        n_bad = 0; n_out = 0; quiet = 1'b0; hold_rx = 1'b0; timed_out = 1'b0; cycle_cnt = 0;
        rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0;
        cfg_we = 1'b0; cfg_addr = CFG_STIFFNESS; cfg_data = '0;
        k_gain = 128; wall_lo = -30720; wall_hi = 30720; floor_lvl = -16640;
        radius = 8960; half_side = 5120; btn_lvl = -17408; grav = 154;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Free space at origin: zero spring, gravity only.
        rows.push_back('{18'sd0, 18'sd0, 18'sd0, 1'b1,
                         '{16'sd0, 16'sd154, 16'sd0, 18'sd0, 18'sd0, 18'sd0}});
        // Sphere center goes straight up.
        rows.push_back('{18'(BALL_X), 18'(BALL_Y), 18'(BALL_Z), 1'b1,
                         '{16'sd0, 16'sd18074, 16'sd0, 18'(BALL_X), 18'sd21760,
                           18'(BALL_Z)}});
        rows.push_back('{-18'sd131072, 18'sd0, 18'sd0, 1'b0, '{default: '0}});
        rows.push_back('{18'sd131071, 18'sd0, 18'sd0, 1'b0, '{default: '0}});
        rows.push_back('{18'sd0, -18'sd131072, 18'sd0, 1'b0, '{default: '0}});
        rows.push_back('{18'sd0, 18'sd131071, -18'sd131072, 1'b0, '{default: '0}});
        rows.push_back('{-18'sd131072, -18'sd131072, 18'sd131071, 1'b0, '{default: '0}});
        rows.push_back('{18'sd131071, 18'sd131071, 18'sd131071, 1'b0, '{default: '0}});
        rows.push_back('{-18'sd14080, 18'sd12801, -18'sd6400, 1'b0, '{default: '0}});
        rows.push_back('{-18'sd10000, 18'sd15000, -18'sd4000, 1'b0, '{default: '0}});
        rows.push_back('{-18'sd14080, 18'sd21759, -18'sd6400, 1'b0, '{default: '0}});
        rows.push_back('{-18'sd14080, 18'sd21760, -18'sd6400, 1'b0, '{default: '0}});
        rows.push_back('{18'(BOX_X), 18'(BOX_Y), 18'(BOX_Z), 1'b0, '{default: '0}});
        rows.push_back('{18'sd16000, 18'sd15360, 18'sd2560, 1'b0, '{default: '0}});
        rows.push_back('{18'sd25000, 18'sd15360, 18'sd2560, 1'b0, '{default: '0}});
        rows.push_back('{18'sd20480, 18'sd11000, 18'sd2560, 1'b0, '{default: '0}});
        rows.push_back('{18'sd20480, 18'sd19900, 18'sd2560, 1'b0, '{default: '0}});
        rows.push_back('{18'sd20480, 18'sd15360, -18'sd2000, 1'b0, '{default: '0}});
        rows.push_back('{18'sd20480, 18'sd15360, 18'sd7000, 1'b0, '{default: '0}});
        rows.push_back('{18'sd17360, 18'sd12240, 18'sd2560, 1'b0, '{default: '0}});
        rows.push_back('{18'sd0, -18'sd18000, 18'sd0, 1'b0, '{default: '0}});
        rows.push_back('{18'sd0, -18'sd17408, 18'sd0, 1'b0, '{default: '0}});
        rows.push_back('{18'sd15360, -18'sd18000, 18'sd0, 1'b0, '{default: '0}});
        rows.push_back('{18'sd0, -18'sd17000, 18'sd0, 1'b0, '{default: '0}});
        foreach (rows[i])
        begin
            row = rows[i];
            send_pos(row.x, row.y, row.z, 1'b0);
            if (row.chk && render_q[$] !== row.want)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("table row %0d predicted %h, expected %h", i, render_q[$], row.want);
            end
        end
        drain();

        // Extreme settings: full gain, inverted walls, huge sphere and cube.
        set_reg(CFG_STIFFNESS, 18'd255);
        set_reg(CFG_LEFT_WALL, 18'h1FFFF);
        set_reg(CFG_RIGHT_WALL, 18'h20000);
        set_reg(CFG_FLOOR, 18'h1FFFF);
        set_reg(CFG_RADIUS, 18'hFFFF);
        set_reg(CFG_HALF_SIDE, 18'hFFFF);
        set_reg(CFG_BUTTON, 18'h20000);
        set_reg(CFG_GRAVITY, 18'h3FF);
        random_block(150);
        drain();

        // Everything disabled: zero gain, no sphere, no cube.
        set_reg(CFG_STIFFNESS, 18'd0);
        set_reg(CFG_RADIUS, 18'd0);
        set_reg(CFG_HALF_SIDE, 18'd0);
        set_reg(CFG_GRAVITY, 18'd0);
        set_reg(CFG_LEFT_WALL, 18'h20000);
        set_reg(CFG_RIGHT_WALL, 18'h1FFFF);
        set_reg(CFG_FLOOR, 18'h20000);
        set_reg(CFG_BUTTON, 18'h1FFFF);
        random_block(100);
        drain();

        // Defaults restored; long receiver hold-off fills the block.
        set_reg(CFG_STIFFNESS, 18'd128);
        set_reg(CFG_LEFT_WALL, -18'sd30720);
        set_reg(CFG_RIGHT_WALL, 18'sd30720);
        set_reg(CFG_FLOOR, -18'sd16640);
        set_reg(CFG_RADIUS, 18'd8960);
        set_reg(CFG_HALF_SIDE, 18'd5120);
        set_reg(CFG_BUTTON, -18'sd17408);
        set_reg(CFG_GRAVITY, 18'd154);
        hold_rx = 1'b1;
        fork
            begin
                for (hold = 0; hold < 300; hold++)
                    @(posedge clk);
                hold_rx = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                send_pos(18'($signed($urandom_range(0, 60000)) - 30000), 18'sd0, 18'sd0, 1'b0);
        join
        random_block(300);
        drain();

        // Mid-range random settings.
        set_reg(CFG_STIFFNESS, 18'($urandom_range(1, 254)));
        set_reg(CFG_LEFT_WALL, 18'(-$signed($urandom_range(0, 40000))));
        set_reg(CFG_RIGHT_WALL, 18'($urandom_range(0, 40000)));
        set_reg(CFG_FLOOR, 18'(-$signed($urandom_range(0, 30000))));
        set_reg(CFG_RADIUS, 18'($urandom_range(100, 20000)));
        set_reg(CFG_HALF_SIDE, 18'($urandom_range(100, 12000)));
        set_reg(CFG_BUTTON, 18'(-$signed($urandom_range(0, 30000))));
        set_reg(CFG_GRAVITY, 18'($urandom_range(0, 1023)));
        random_block(300);
        // Sender waits for every result before going on.
        while (render_q.size() != 0)
            @(negedge clk);
        quiet = 1'b1;
        random_block(250);
        drain();

        if (n_bad == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
